// File: rtl/dam_pkg.sv
// shared types and constants of the dns a-record answer matcher
`default_nettype none

package dam_pkg;

  localparam int MaxReplyBytes = 512;
  localparam int ByteCountW    = $clog2(MaxReplyBytes + 1);

  localparam int DnsHeaderLen  = 12;
  localparam int QFixedLen     = 4;
  localparam int AFixedLen     = 10;

  localparam int HdrIdIdx      = 1;
  localparam int HdrFlagsIdx   = 3;
  localparam int HdrQdIdx      = 5;
  localparam int HdrAnIdx      = 7;
  localparam int AnsTypeIdx    = 1;
  localparam int AnsClassIdx   = 3;

  localparam logic [15:0] DnsQtypeA   = 16'd1;
  localparam logic [15:0] DnsQclassIn = 16'd1;
  localparam logic [15:0] FlagQrMask  = 16'h8000;
  localparam logic [15:0] RcodeMask   = 16'h000f;
  localparam logic [7:0]  PtrMask     = 8'hc0;

  typedef enum logic [3:0] {
    PH_HEADER  = 4'd0,
    PH_Q_NAME  = 4'd1,
    PH_Q_LABEL = 4'd2,
    PH_Q_PTR   = 4'd3,
    PH_Q_FIXED = 4'd4,
    PH_A_NAME  = 4'd5,
    PH_A_LABEL = 4'd6,
    PH_A_PTR   = 4'd7,
    PH_A_FIXED = 4'd8,
    PH_A_RDATA = 4'd9,
    PH_DONE    = 4'd10
  } phase_t;

  typedef enum logic [2:0] {
    V_MATCH     = 3'd0,
    V_SHORT     = 3'd1,
    V_ID        = 3'd2,
    V_FLAGS     = 3'd3,
    V_MALFORMED = 3'd4,
    V_NOMATCH   = 3'd5
  } verdict_t;

  typedef enum logic {
    CFG_EXPECTED_ID   = 1'b0,
    CFG_EXPECTED_ADDR = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    logic     found;
    verdict_t verdict;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/dam_in_stage.sv
// input register stage holding one accepted byte item
`default_nettype none

module dam_in_stage (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire dam_pkg::item_t in_item,
  input  wire logic          take,
  output logic               s1_valid,
  output dam_pkg::item_t     s1_item
);
  import dam_pkg::*;

  logic  s1_valid_r;
  item_t s1_item_r;

  // the slot frees when the parser consumes the held item
  assign in_ready = !s1_valid_r || take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_item_r <= in_item;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_item  = s1_item_r;

endmodule

`default_nettype wire

// File: rtl/dam_parser.sv
// per-byte dns reply parser state and verdict logic
`default_nettype none

module dam_parser (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           step,
  input  wire dam_pkg::item_t item,
  input  wire logic [15:0]    expected_id,
  input  wire logic [31:0]    expected_addr,
  output dam_pkg::result_t    result
);
  import dam_pkg::*;

  phase_t                phase_r,          phase_nxt;
  logic [ByteCountW-1:0] byte_total_r,     byte_total_nxt;
  logic [3:0]            field_index_r,    field_index_nxt;
  logic [15:0]           field_shift_r,    field_shift_nxt;
  logic [15:0]           questions_left_r, questions_left_nxt;
  logic [15:0]           answers_left_r,   answers_left_nxt;
  logic [5:0]            label_left_r,     label_left_nxt;
  logic                  type_a_r,         type_a_nxt;
  logic                  class_in_r,       class_in_nxt;
  logic [15:0]           rdata_left_r,     rdata_left_nxt;
  logic                  address_equal_r,  address_equal_nxt;
  logic                  match_seen_r,     match_seen_nxt;
  verdict_t              fail_code_r,      fail_code_nxt;

  logic [7:0]  b;
  logic [15:0] shifted;
  logic [1:0]  ip_sel;
  logic [7:0]  ip_byte;
  logic        in_window;

  assign b         = item.data_byte;
  assign shifted   = {field_shift_r[7:0], b};
  assign ip_sel    = rdata_left_r[1:0] - 2'd1;
  assign ip_byte   = 8'(expected_addr >> {ip_sel, 3'b000});
  assign in_window = byte_total_r < ByteCountW'(MaxReplyBytes);

  // next state of the parser for the byte in the input register
  always_comb begin
    phase_nxt          = phase_r;
    byte_total_nxt     = byte_total_r;
    field_index_nxt    = field_index_r;
    field_shift_nxt    = field_shift_r;
    questions_left_nxt = questions_left_r;
    answers_left_nxt   = answers_left_r;
    label_left_nxt     = label_left_r;
    type_a_nxt         = type_a_r;
    class_in_nxt       = class_in_r;
    rdata_left_nxt     = rdata_left_r;
    address_equal_nxt  = address_equal_r;
    match_seen_nxt     = match_seen_r;
    fail_code_nxt      = fail_code_r;

    if (in_window) begin
      byte_total_nxt = byte_total_r + ByteCountW'(1);
      unique case (phase_r)
        PH_HEADER: begin
          field_shift_nxt = shifted;
          field_index_nxt = field_index_r + 4'd1;
          if (field_index_r == 4'(HdrIdIdx) && shifted != expected_id) begin
            fail_code_nxt = V_ID;
            phase_nxt     = PH_DONE;
          end else if (field_index_r == 4'(HdrFlagsIdx) &&
                       ((shifted & FlagQrMask) == 16'd0 ||
                        (shifted & RcodeMask) != 16'd0)) begin
            fail_code_nxt = V_FLAGS;
            phase_nxt     = PH_DONE;
          end else begin
            if (field_index_r == 4'(HdrQdIdx)) questions_left_nxt = shifted;
            if (field_index_r == 4'(HdrAnIdx)) answers_left_nxt = shifted;
            if (field_index_nxt >= 4'(DnsHeaderLen)) begin
              field_index_nxt = 4'd0;
              if (questions_left_r != 16'd0) begin
                phase_nxt = PH_Q_NAME;
              end else if (answers_left_r == 16'd0) begin
                phase_nxt = PH_DONE;
              end else begin
                phase_nxt = PH_A_NAME;
              end
            end
          end
        end
        PH_Q_NAME, PH_A_NAME: begin
          if ((b & PtrMask) == PtrMask) begin
            phase_nxt = (phase_r == PH_A_NAME) ? PH_A_PTR : PH_Q_PTR;
          end else if ((b & PtrMask) != 8'd0) begin
            // label types 01 and 10
            fail_code_nxt = V_MALFORMED;
            phase_nxt     = PH_DONE;
          end else if (b == 8'd0) begin
            field_index_nxt = 4'd0;
            phase_nxt = (phase_r == PH_A_NAME) ? PH_A_FIXED : PH_Q_FIXED;
          end else begin
            label_left_nxt = b[5:0];
            phase_nxt = (phase_r == PH_A_NAME) ? PH_A_LABEL : PH_Q_LABEL;
          end
        end
        PH_Q_LABEL, PH_A_LABEL: begin
          label_left_nxt = label_left_r - 6'd1;
          if (label_left_nxt == 6'd0) begin
            phase_nxt = (phase_r == PH_A_LABEL) ? PH_A_NAME : PH_Q_NAME;
          end
        end
        PH_Q_PTR, PH_A_PTR: begin
          field_index_nxt = 4'd0;
          phase_nxt = (phase_r == PH_A_PTR) ? PH_A_FIXED : PH_Q_FIXED;
        end
        PH_Q_FIXED: begin
          field_index_nxt = field_index_r + 4'd1;
          if (field_index_nxt >= 4'(QFixedLen)) begin
            field_index_nxt    = 4'd0;
            questions_left_nxt = questions_left_r - 16'd1;
            if (questions_left_nxt != 16'd0) begin
              phase_nxt = PH_Q_NAME;
            end else if (answers_left_r == 16'd0) begin
              phase_nxt = PH_DONE;
            end else begin
              phase_nxt = PH_A_NAME;
            end
          end
        end
        PH_A_FIXED: begin
          field_shift_nxt = shifted;
          if (field_index_r == 4'(AnsTypeIdx)) type_a_nxt = (shifted == DnsQtypeA);
          if (field_index_r == 4'(AnsClassIdx)) class_in_nxt = (shifted == DnsQclassIn);
          field_index_nxt = field_index_r + 4'd1;
          if (field_index_nxt >= 4'(AFixedLen)) begin
            field_index_nxt   = 4'd0;
            rdata_left_nxt    = shifted;
            address_equal_nxt = type_a_r && class_in_r && (shifted == 16'd4);
            if (shifted == 16'd0) begin
              answers_left_nxt = answers_left_r - 16'd1;
              phase_nxt = (answers_left_nxt == 16'd0) ? PH_DONE : PH_A_NAME;
            end else begin
              phase_nxt = PH_A_RDATA;
            end
          end
        end
        PH_A_RDATA: begin
          if (address_equal_r && rdata_left_r >= 16'd1 && rdata_left_r <= 16'd4 &&
              ip_byte != b) begin
            address_equal_nxt = 1'b0;
          end
          rdata_left_nxt = rdata_left_r - 16'd1;
          if (rdata_left_nxt == 16'd0) begin
            if (address_equal_nxt) begin
              match_seen_nxt = 1'b1;
              phase_nxt      = PH_DONE;
            end else begin
              answers_left_nxt = answers_left_r - 16'd1;
              phase_nxt = (answers_left_nxt == 16'd0) ? PH_DONE : PH_A_NAME;
            end
          end
        end
        PH_DONE: begin
        end
        default: begin
        end
      endcase
    end
  end

  // verdict from the state after this byte
  always_comb begin
    result.verdict = V_MALFORMED;
    if (byte_total_nxt < ByteCountW'(DnsHeaderLen)) begin
      result.verdict = V_SHORT;
    end else if (match_seen_nxt) begin
      result.verdict = V_MATCH;
    end else if (fail_code_nxt != V_MATCH) begin
      result.verdict = fail_code_nxt;
    end else if (phase_nxt == PH_DONE) begin
      result.verdict = V_NOMATCH;
    end
    result.found = (result.verdict == V_MATCH);
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (step && item.last_byte)) begin
      phase_r          <= PH_HEADER;
      byte_total_r     <= '0;
      field_index_r    <= '0;
      field_shift_r    <= '0;
      questions_left_r <= '0;
      answers_left_r   <= '0;
      label_left_r     <= '0;
      type_a_r         <= 1'b0;
      class_in_r       <= 1'b0;
      rdata_left_r     <= '0;
      address_equal_r  <= 1'b1;
      match_seen_r     <= 1'b0;
      fail_code_r      <= V_MATCH;
    end else if (step) begin
      phase_r          <= phase_nxt;
      byte_total_r     <= byte_total_nxt;
      field_index_r    <= field_index_nxt;
      field_shift_r    <= field_shift_nxt;
      questions_left_r <= questions_left_nxt;
      answers_left_r   <= answers_left_nxt;
      label_left_r     <= label_left_nxt;
      type_a_r         <= type_a_nxt;
      class_in_r       <= class_in_nxt;
      rdata_left_r     <= rdata_left_nxt;
      address_equal_r  <= address_equal_nxt;
      match_seen_r     <= match_seen_nxt;
      fail_code_r      <= fail_code_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/dam_out_stage.sv
// result register toward the output channel
`default_nettype none

module dam_out_stage (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             load,
  input  wire dam_pkg::result_t result,
  output logic                  can_load,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output dam_pkg::result_t      out_result
);
  import dam_pkg::*;

  logic    out_valid_r;
  result_t out_result_r;

  assign can_load = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (can_load) begin
      out_valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (can_load && load) begin
      out_result_r <= result;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;

endmodule

`default_nettype wire

// File: rtl/dns_a_answer_matcher_core.sv
// top level of the dns reply a-record answer matcher
//
// usage: a dns reply datagram enters one byte per item on the in_ channel,
// with in_last_byte set on its final byte. only the final byte produces an
// item on the out_ channel: out_found and out_verdict (0 match, 1 short
// header, 2 id mismatch, 3 not a response or rcode set, 4 malformed or
// truncated, 5 no matching answer). bytes beyond the reply buffer size are
// not parsed, but their last flag still ends the datagram.
// cfg_we writes expected_id (index 0) or expected_addr (index 1) from
// cfg_data; write only while no datagram is in flight. a byte is
// registered at the input and parsed from there; the result of a final
// byte lands in the output register, which raises out_valid. the block
// takes one byte per cycle while no final byte waits for the result
// register.
// reset (synchronous, active low) clears the parser, both registers and
// both stages. when the receiver stalls, non-final bytes keep flowing; a
// final byte waits in the input register until the result register frees.
`default_nettype none

module dns_a_answer_matcher_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_last_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_found,
  output logic [2:0]       out_verdict,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data
);
  import dam_pkg::*;

  logic [15:0] expected_id_r;
  logic [31:0] expected_addr_r;

  item_t   in_item;
  item_t   s1_item;
  logic    s1_valid;
  logic    take;
  logic    step;
  logic    can_load;
  result_t result;
  result_t out_result;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expected_id_r   <= '0;
      expected_addr_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_EXPECTED_ID:   expected_id_r <= cfg_data[15:0];
        CFG_EXPECTED_ADDR: expected_addr_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign in_item.data_byte = in_data_byte;
  assign in_item.last_byte = in_last_byte;

  // a final byte needs a free result slot, other bytes never wait
  assign take = !s1_item.last_byte || can_load;
  assign step = s1_valid && take;

  dam_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .take     (take),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  dam_parser u_parser (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (step),
    .item          (s1_item),
    .expected_id   (expected_id_r),
    .expected_addr (expected_addr_r),
    .result        (result)
  );

  dam_out_stage u_out_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (step && s1_item.last_byte),
    .result     (result),
    .can_load   (can_load),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_result (out_result)
  );

  assign out_found   = out_result.found;
  assign out_verdict = out_result.verdict;

endmodule

`default_nettype wire
